/* rtl/core/ccm_pkg.sv */
// Shared types, constants and a helper function of the color correction matrix.
`timescale 1ns / 1ps

package ccm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COEF_ROW0 = 3'd0;
  localparam logic [2:0] CFG_COEF_ROW1 = 3'd1;
  localparam logic [2:0] CFG_COEF_ROW2 = 3'd2;
  localparam logic [2:0] CFG_OFFSETS   = 3'd3;
  localparam logic [2:0] CFG_TEN_BIT   = 3'd4;

  localparam int unsigned SampleW = 10;
  localparam int unsigned CfgW    = 24;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] CoefRow0Rst = 24'hE5F960;
  localparam logic [CfgW-1:0] CoefRow1Rst = 24'h0550E7;
  localparam logic [CfgW-1:0] CoefRow2Rst = 24'h5EE6F3;
  localparam logic [CfgW-1:0] OffsetsRst  = 24'h000000;

  // Coefficient and saturation constants.
  localparam logic [7:0]         CoefMostNeg = 8'h80;
  localparam logic [6:0]         MagMax      = 7'h7f;
  localparam logic [12:0]        OfsExtAdd   = 13'h0070;
  localparam logic [SampleW-1:0] Max10       = 10'd1023;
  localparam logic [SampleW-1:0] Max8        = 10'd255;

  typedef struct packed {
    logic [SampleW-1:0] in_red;
    logic [SampleW-1:0] in_green;
    logic [SampleW-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [SampleW-1:0] out_red;
    logic [SampleW-1:0] out_green;
    logic [SampleW-1:0] out_blue;
  } pix_out_t;

  // Magnitude of a two's-complement coefficient; the most negative code
  // saturates to the largest magnitude.
  function automatic logic [6:0] coef_mag(input logic [7:0] coef);
    logic [7:0] negv;
    negv = 8'(~coef + 8'd1);
    if (coef == CoefMostNeg) begin
      coef_mag = MagMax;
    end else if (coef[7]) begin
      coef_mag = negv[6:0];
    end else begin
      coef_mag = coef[6:0];
    end
  endfunction

endpackage

/* rtl/core/ccm_product.sv */
// Two-stage shift-and-add product of one sample and one 1/64 coefficient.
`timescale 1ns / 1ps

module ccm_product
  import ccm_pkg::*;
(
  input  logic               clk_i,
  input  logic [SampleW-1:0] pix_i,
  input  logic [7:0]         coef_i,
  output logic [11:0]        prod_o
);

  logic [6:0]  mag;
  logic [11:0] s01_d, s01_q;
  logic [9:0]  s48_d, s48_q;
  logic [7:0]  s16_d, s16_q;
  logic [4:0]  s64_d, s64_q;
  logic        neg_q;
  logic [11:0] total;
  logic [10:0] half;
  logic [11:0] prod_d, prod_q;

  // First stage: decode the coefficient and form pairwise partial sums.
  always_comb begin
    mag   = coef_mag(coef_i);
    s01_d = (mag[6] ? {1'b0, pix_i, 1'b0} : 12'd0) + (mag[5] ? {2'b00, pix_i} : 12'd0);
    s48_d = (mag[4] ? {1'b0, pix_i[9:1]} : 10'd0) + (mag[3] ? {2'b00, pix_i[9:2]} : 10'd0);
    s16_d = (mag[2] ? {1'b0, pix_i[9:3]} : 8'd0) + (mag[1] ? {2'b00, pix_i[9:4]} : 8'd0);
    s64_d = mag[0] ? pix_i[9:5] : 5'd0;
  end

  always_ff @(posedge clk_i) begin
    s01_q <= s01_d;
    s48_q <= s48_d;
    s16_q <= s16_d;
    s64_q <= s64_d;
    neg_q <= coef_i[7];
  end

  // Second stage: wrap to 12 bits, halve, and negate for negative coefficients.
  always_comb begin
    total  = 12'(s01_q + {2'b00, s48_q}) + 12'({4'd0, s16_q} + {7'd0, s64_q});
    half   = total[11:1];
    prod_d = neg_q ? 12'(~{1'b0, half} + 12'd1) : {1'b0, half};
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/ccm_channel.sv */
// Sum of three products and an offset, clamped to the sample range.
`timescale 1ns / 1ps

module ccm_channel
  import ccm_pkg::*;
(
  input  logic               clk_i,
  input  logic [11:0]        prod_r_i,
  input  logic [11:0]        prod_g_i,
  input  logic [11:0]        prod_b_i,
  input  logic [7:0]         ofs_i,
  input  logic               ten_bit_i,
  output logic [SampleW-1:0] res_o
);

  logic [12:0]        sum_rg;
  logic [12:0]        sum_bo;
  logic [13:0]        total;
  logic [SampleW-1:0] res_d, res_q;

  // Sign-extended sums, then saturation to zero or full scale.
  always_comb begin
    sum_rg = {prod_r_i[11], prod_r_i} + {prod_g_i[11], prod_g_i};
    sum_bo = {prod_b_i[11], prod_b_i} + (ofs_i[7] ? OfsExtAdd : 13'd0) + {5'd0, ofs_i};
    total  = {sum_rg[12], sum_rg} + {sum_bo[12], sum_bo};
    if (total[13]) begin
      res_d = '0;
    end else if (total[12:10] != 3'd0) begin
      res_d = Max10;
    end else begin
      res_d = total[9:0];
    end
    if (!ten_bit_i && res_d > Max8) begin
      res_d = Max8;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* rtl/core/color_correction_matrix.sv */
// Top level of the 3x3 color correction matrix with its configuration registers.
// Usage:
//   A pixel request is taken at a rising edge where start_i is high and busy_o
//   is low; busy_o is always low, so one pixel may enter in every cycle.
//   The corrected pixel is on pix_o for exactly one cycle, marked by done_o,
//   once it has passed the partial-sum, product and channel-sum registers.
//   Throughput is one pixel per cycle through the three register stages:
//   partial sums, product, and clamped channel sum.
//   Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i
//   with no read-back; indexes beyond the register list are ignored. The
//   user must change registers only while no pixel is in flight (not enforced).
//   Index 0..2 hold coefficient rows, 3 the offsets, 4 the ten-bit mode.
//   Reset clears all valid bits and loads the default coefficients, zero
//   offsets and ten-bit mode.
//   The receiver cannot stall; each result must be taken in its cycle.
`timescale 1ns / 1ps

module color_correction_matrix
  import ccm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  pix_in_t         pix_i,
  output logic            done_o,
  output pix_out_t        pix_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  logic [CfgW-1:0]    coef_q [3];
  logic [CfgW-1:0]    offsets_q;
  logic               ten_bit_q;
  logic [2:0]         vld_q;
  logic [SampleW-1:0] pix_m [3];
  logic [11:0]        prod [3][3];
  logic [SampleW-1:0] res [3];

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= CoefRow0Rst;
      coef_q[1] <= CoefRow1Rst;
      coef_q[2] <= CoefRow2Rst;
      offsets_q <= OffsetsRst;
      ten_bit_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_ROW0: coef_q[0] <= cfg_wdata_i;
        CFG_COEF_ROW1: coef_q[1] <= cfg_wdata_i;
        CFG_COEF_ROW2: coef_q[2] <= cfg_wdata_i;
        CFG_OFFSETS:   offsets_q <= cfg_wdata_i;
        CFG_TEN_BIT:   ten_bit_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Valid bits follow the pixel through the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[2];

  // Input masking for eight-bit mode.
  always_comb begin
    pix_m[0] = ten_bit_q ? pix_i.in_red   : {2'b00, pix_i.in_red[7:0]};
    pix_m[1] = ten_bit_q ? pix_i.in_green : {2'b00, pix_i.in_green[7:0]};
    pix_m[2] = ten_bit_q ? pix_i.in_blue  : {2'b00, pix_i.in_blue[7:0]};
  end

  // Nine product units, one per coefficient, and one sum unit per output.
  for (genvar row = 0; row < 3; row++) begin : g_row
    for (genvar col = 0; col < 3; col++) begin : g_col
      ccm_product u_prod (
        .clk_i  (clk_i),
        .pix_i  (pix_m[col]),
        .coef_i (coef_q[row][col*8 +: 8]),
        .prod_o (prod[row][col])
      );
    end
    ccm_channel u_chan (
      .clk_i     (clk_i),
      .prod_r_i  (prod[row][0]),
      .prod_g_i  (prod[row][1]),
      .prod_b_i  (prod[row][2]),
      .ofs_i     (offsets_q[row*8 +: 8]),
      .ten_bit_i (ten_bit_q),
      .res_o     (res[row])
    );
  end

  assign pix_o.out_red   = res[0];
  assign pix_o.out_green = res[1];
  assign pix_o.out_blue  = res[2];

endmodule
